FILE: rtl/hne_pkg.sv
// ----------------------------------------------------------------------------
// hne_pkg
// Shared constants, codes and widths of the height-map normal engine.
// ----------------------------------------------------------------------------
package hne_pkg;

	// Grid geometry
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_LENGTH = 64;
	localparam int CELLS      = MAX_WIDTH * MAX_LENGTH;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_LENGTH);
	localparam int WDIM_W     = $clog2(MAX_WIDTH + 1);
	localparam int LDIM_W     = $clog2(MAX_LENGTH + 1);

	// Configuration port
	localparam int PADDR_W   = 3;
	localparam int CFG_W     = 7;
	localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

	typedef enum logic {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_LENGTH = 1'b1
	} reg_t;

	// Item codes
	typedef enum logic [1:0] {
		OP_WRITE       = 2'd0,
		OP_READ_HEIGHT = 2'd1,
		OP_READ_NORMAL = 2'd2
	} op_t;

	// Field widths
	localparam int HEIGHT_W = 16;
	localparam int NORM_W   = 17;
	localparam int ROUGH_W  = 16;
	localparam int DIFF_W   = 17;
	localparam int SUM_W    = 18;
	localparam int SQR_W    = 32;

	// Arithmetic of the unit normals
	localparam int SQ_W       = 50;
	localparam int ROOT_W     = 25;
	localparam int ROOT_STEPS = 25;
	localparam int DIV_W      = 38;
	localparam int DIV_SHIFT  = 21;
	localparam int QUO_W      = 13;
	localparam int DIV_STEPS  = QUO_W;
	localparam int UNIT_Y     = 256;
	localparam int SQ_BIAS    = 65536;
	localparam int ONE_Q12    = 4096;
	localparam int NORM_LIMIT = 49152;

	// Neighbor slots, in the order they are fetched
	localparam int NB_COUNT = 5;
	localparam logic [2:0] NB_C  = 3'd0;
	localparam logic [2:0] NB_UP = 3'd1;
	localparam logic [2:0] NB_DN = 3'd2;
	localparam logic [2:0] NB_LF = 3'd3;
	localparam logic [2:0] NB_RT = 3'd4;

endpackage

FILE: rtl/hne_if.sv
// ----------------------------------------------------------------------------
// hne_req_if / hne_rsp_if
// Valid/ready channels of the height-map normal engine.
// ----------------------------------------------------------------------------
interface hne_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            operation;
	logic [5:0]                            column;
	logic [5:0]                            row;
	logic signed [hne_pkg::HEIGHT_W-1:0]   height_value;

	modport source (output valid, operation, column, row, height_value, input ready);
	modport sink   (input valid, operation, column, row, height_value, output ready);
endinterface

interface hne_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [hne_pkg::HEIGHT_W-1:0]   height_out;
	logic signed [hne_pkg::NORM_W-1:0]     normal_x;
	logic signed [hne_pkg::NORM_W-1:0]     normal_y;
	logic signed [hne_pkg::NORM_W-1:0]     normal_z;

	modport source (output valid, height_out, normal_x, normal_y, normal_z, input ready);
	modport sink   (input valid, height_out, normal_x, normal_y, normal_z, output ready);
endinterface

FILE: rtl/hne_ram.sv
// ----------------------------------------------------------------------------
// hne_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hne_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/heightmap_normal_engine.sv
// ----------------------------------------------------------------------------
// heightmap_normal_engine
// Height grid with lazily recomputed, smoothed vertex normals.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  -------  ---  ---------------------------------------------------------
//  req      in   operation, column, row, height_value
//  rsp      out  height_out, normal_x, normal_y, normal_z (one beat a read)
//  apb      in   grid_width at 0x0, grid_length at 0x4
//
//  A write is done in the idle state; a height read or a normal read of
//  fresh normals passes its read state and the response state, where it
//  waits for the response register to drain. The first normal read after
//  a write or a register write recomputes the grid: a first pass puts each
//  in-grid triangle through the 25-step square root and 13-step dividers,
//  which dominate, and a second pass smooths each point. The three stores
//  are single-port-read RAMs, one read a cycle. Reset clears only control.
// ----------------------------------------------------------------------------
module heightmap_normal_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hne_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	hne_req_if.sink                       req,
	hne_rsp_if.source                     rsp
);

	typedef enum logic [4:0] {
		S_IDLE, S_HEIGHT, S_NORMAL, S_RESP, S_FETCH,
		S_P1_RD, S_P1_CAP, S_P1_TRI, S_P1_SQP, S_P1_SQQ, S_P1_ROOT_LD, S_P1_ROOT,
		S_P1_DIV_LD, S_P1_DIV, S_P1_ACC, S_P1_WR,
		S_P2_RD, S_P2_CAP, S_P2_SUM, S_P2_WR
	} state_t;

	state_t state_q;

	logic [hne_pkg::CFG_W-1:0] width_q, length_q;
	logic                      valid_q;
	logic                      rsp_valid_q;
	logic                      rsp_load;
	logic signed [hne_pkg::HEIGHT_W-1:0] rsp_height_q;
	logic signed [hne_pkg::NORM_W-1:0]   rsp_n_q [3];

	logic signed [hne_pkg::HEIGHT_W-1:0] res_height_q;
	logic signed [hne_pkg::NORM_W-1:0]   res_n_q [3];
	logic [hne_pkg::ADDR_W-1:0]          addr_q;

	logic [hne_pkg::WDIM_W-1:0] eff_w;
	logic [hne_pkg::LDIM_W-1:0] eff_l;
	logic                       req_inside;
	logic [hne_pkg::ADDR_W-1:0] req_addr;
	hne_pkg::op_t               req_op;
	logic                       cfg_wr;

	// Grid walk
	logic [hne_pkg::COL_W-1:0]  x_q;
	logic [hne_pkg::ROW_W-1:0]  z_q;
	logic [hne_pkg::ADDR_W-1:0] base_q;
	logic [2:0]                 rd_q;
	logic [1:0]                 tri_q;
	logic [4:0]                 it_q;
	logic [hne_pkg::ADDR_W-1:0] idx;
	logic [hne_pkg::ADDR_W-1:0] nb_addr;
	logic                       has_up, has_dn, has_lf, has_rt;
	logic [hne_pkg::NB_COUNT-1:0] has_vec;

	// First pass
	logic signed [hne_pkg::HEIGHT_W-1:0] nb_q [hne_pkg::NB_COUNT];
	logic signed [hne_pkg::DIFF_W-1:0]   d_up, d_dn, d_lf, d_rt;
	logic signed [hne_pkg::DIFF_W-1:0]   tri_p, tri_qv;
	logic                                tri_en;
	logic signed [hne_pkg::DIFF_W-1:0]   p_q, q_q;
	logic signed [hne_pkg::DIFF_W-1:0]   mul_a;
	logic signed [2*hne_pkg::DIFF_W-1:0] sq_full;
	logic [hne_pkg::SQR_W-1:0]           psq_q, qsq_q;
	logic [hne_pkg::SQ_W-1:0]            sqx_q, root_q, bit_v, root_t;
	logic                                root_ge;
	logic [hne_pkg::DIFF_W-1:0]          mag_n [3];
	logic                                neg_n [3];
	logic [hne_pkg::DIV_W-1:0]           rem_q [3];
	logic [hne_pkg::DIV_W-1:0]           dsr_q;
	logic [hne_pkg::QUO_W-1:0]           quo_q [3];
	logic signed [hne_pkg::ROUGH_W-1:0]  acc_q [3];

	// Second pass
	logic signed [hne_pkg::ROUGH_W-1:0]  rn_q [hne_pkg::NB_COUNT][3];
	logic signed [hne_pkg::SUM_W-1:0]    sum_c [3];
	logic signed [hne_pkg::SUM_W-1:0]    d_q [3];
	logic signed [hne_pkg::SUM_W-1:0]    d_eff [3];
	logic [hne_pkg::SUM_W-1:0]           hmag [3];
	logic [hne_pkg::SUM_W-1:0]           hhalf [3];
	logic signed [hne_pkg::NORM_W-1:0]   nval [3];
	logic                                d_zero;

	// Memories
	logic                                 h_we;
	logic [hne_pkg::ADDR_W-1:0]           h_raddr;
	logic [hne_pkg::HEIGHT_W-1:0]         h_rdata;
	logic                                 r_we;
	logic [3*hne_pkg::ROUGH_W-1:0]        r_wdata, r_rdata;
	logic                                 s_we;
	logic [hne_pkg::ADDR_W-1:0]           s_raddr;
	logic [3*hne_pkg::NORM_W-1:0]         s_wdata, s_rdata;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (hne_pkg::reg_t'(paddr[2]) == hne_pkg::REG_GRID_LENGTH) ?
		32'(length_q) : 32'(width_q);

	always_comb begin
		int wi;
		int li;
		wi = int'(width_q);
		li = int'(length_q);
		if (wi < 1) wi = 1;
		else if (wi > hne_pkg::MAX_WIDTH) wi = hne_pkg::MAX_WIDTH;
		if (li < 1) li = 1;
		else if (li > hne_pkg::MAX_LENGTH) li = hne_pkg::MAX_LENGTH;
		eff_w = hne_pkg::WDIM_W'(wi);
		eff_l = hne_pkg::LDIM_W'(li);
	end

	// ------------------------------------------------------------------
	// Request decode
	// ------------------------------------------------------------------
	assign req_op     = hne_pkg::op_t'(req.operation);
	assign req_inside = (32'(req.column) < 32'(eff_w)) && (32'(req.row) < 32'(eff_l));
	assign req_addr   = hne_pkg::ADDR_W'(32'(req.row) * hne_pkg::MAX_WIDTH + 32'(req.column));
	assign req.ready  = (state_q == S_IDLE);

	assign rsp.valid      = rsp_valid_q;
	assign rsp.height_out = rsp_height_q;
	assign rsp.normal_x   = rsp_n_q[0];
	assign rsp.normal_y   = rsp_n_q[1];
	assign rsp.normal_z   = rsp_n_q[2];

	// The response register takes a new beat once it is empty or being drained.
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);

	// ------------------------------------------------------------------
	// Grid walk and neighbor addressing
	// ------------------------------------------------------------------
	assign idx    = base_q + hne_pkg::ADDR_W'(x_q);
	assign has_up = (z_q != '0);
	assign has_dn = (hne_pkg::LDIM_W'(z_q) + hne_pkg::LDIM_W'(1)) < eff_l;
	assign has_lf = (x_q != '0);
	assign has_rt = (hne_pkg::WDIM_W'(x_q) + hne_pkg::WDIM_W'(1)) < eff_w;
	assign has_vec = {has_rt, has_lf, has_dn, has_up, 1'b1};

	always_comb begin
		unique case (rd_q)
			hne_pkg::NB_UP: nb_addr = idx - hne_pkg::ADDR_W'(hne_pkg::MAX_WIDTH);
			hne_pkg::NB_DN: nb_addr = idx + hne_pkg::ADDR_W'(hne_pkg::MAX_WIDTH);
			hne_pkg::NB_LF: nb_addr = idx - hne_pkg::ADDR_W'(1);
			hne_pkg::NB_RT: nb_addr = idx + hne_pkg::ADDR_W'(1);
			default:        nb_addr = idx;
		endcase
	end

	// ------------------------------------------------------------------
	// First pass: triangle selection, square root and dividers
	// ------------------------------------------------------------------
	assign d_up = hne_pkg::DIFF_W'(nb_q[hne_pkg::NB_UP]) - hne_pkg::DIFF_W'(nb_q[hne_pkg::NB_C]);
	assign d_dn = hne_pkg::DIFF_W'(nb_q[hne_pkg::NB_DN]) - hne_pkg::DIFF_W'(nb_q[hne_pkg::NB_C]);
	assign d_lf = hne_pkg::DIFF_W'(nb_q[hne_pkg::NB_LF]) - hne_pkg::DIFF_W'(nb_q[hne_pkg::NB_C]);
	assign d_rt = hne_pkg::DIFF_W'(nb_q[hne_pkg::NB_RT]) - hne_pkg::DIFF_W'(nb_q[hne_pkg::NB_C]);

	always_comb begin
		unique case (tri_q)
			2'd0: begin
				tri_en = has_lf && has_up;
				tri_p  = d_lf;
				tri_qv = d_up;
			end
			2'd1: begin
				tri_en = has_lf && has_dn;
				tri_p  = d_lf;
				tri_qv = -d_dn;
			end
			2'd2: begin
				tri_en = has_rt && has_dn;
				tri_p  = -d_rt;
				tri_qv = -d_dn;
			end
			default: begin
				tri_en = has_rt && has_up;
				tri_p  = -d_rt;
				tri_qv = d_up;
			end
		endcase
	end

	// One squarer shared by both components.
	assign mul_a   = (state_q == S_P1_SQP) ? p_q : q_q;
	assign sq_full = mul_a * mul_a;

	assign bit_v   = hne_pkg::SQ_W'(1) << {it_q, 1'b0};
	assign root_t  = root_q + bit_v;
	assign root_ge = (sqx_q >= root_t);

	assign neg_n[0] = p_q[hne_pkg::DIFF_W-1];
	assign neg_n[1] = 1'b0;
	assign neg_n[2] = q_q[hne_pkg::DIFF_W-1];
	assign mag_n[0] = neg_n[0] ? hne_pkg::DIFF_W'(-p_q) : hne_pkg::DIFF_W'(p_q);
	assign mag_n[1] = hne_pkg::DIFF_W'(hne_pkg::UNIT_Y);
	assign mag_n[2] = neg_n[2] ? hne_pkg::DIFF_W'(-q_q) : hne_pkg::DIFF_W'(q_q);

	assign r_wdata = {acc_q[2], acc_q[1], acc_q[0]};

	// ------------------------------------------------------------------
	// Second pass: neighbor sum, halving with rounding, saturation
	// ------------------------------------------------------------------
	assign d_zero = (d_q[0] == '0) && (d_q[1] == '0) && (d_q[2] == '0);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_c[c] = (hne_pkg::SUM_W'(rn_q[hne_pkg::NB_C][c]) <<< 1)
				+ hne_pkg::SUM_W'(rn_q[hne_pkg::NB_UP][c])
				+ hne_pkg::SUM_W'(rn_q[hne_pkg::NB_DN][c])
				+ hne_pkg::SUM_W'(rn_q[hne_pkg::NB_LF][c])
				+ hne_pkg::SUM_W'(rn_q[hne_pkg::NB_RT][c]);
			// A flat or empty neighborhood points straight up.
			d_eff[c] = (d_zero && c == 1) ? hne_pkg::SUM_W'(2 * hne_pkg::ONE_Q12) : d_q[c];
			hmag[c]  = d_eff[c][hne_pkg::SUM_W-1] ? hne_pkg::SUM_W'(-d_eff[c]) :
				hne_pkg::SUM_W'(d_eff[c]);
			hhalf[c] = (hmag[c] + hne_pkg::SUM_W'(1)) >> 1;
			if (hhalf[c] > hne_pkg::SUM_W'(hne_pkg::NORM_LIMIT)) begin
				hhalf[c] = hne_pkg::SUM_W'(hne_pkg::NORM_LIMIT);
			end
			nval[c] = d_eff[c][hne_pkg::SUM_W-1] ? -hne_pkg::NORM_W'(hhalf[c]) :
				hne_pkg::NORM_W'(hhalf[c]);
		end
	end

	assign s_wdata = {nval[2], nval[1], nval[0]};

	// ------------------------------------------------------------------
	// Memories
	// ------------------------------------------------------------------
	assign h_we    = (state_q == S_IDLE) && req.valid && (req_op == hne_pkg::OP_WRITE) &&
		req_inside;
	assign h_raddr = (state_q == S_IDLE) ? req_addr : nb_addr;
	assign r_we    = (state_q == S_P1_WR);
	assign s_we    = (state_q == S_P2_WR);
	assign s_raddr = (state_q == S_IDLE) ? req_addr : addr_q;

	hne_ram #(.WIDTH(hne_pkg::HEIGHT_W), .DEPTH(hne_pkg::CELLS)) u_height_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (req_addr),
		.wdata (req.height_value),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	hne_ram #(.WIDTH(3 * hne_pkg::ROUGH_W), .DEPTH(hne_pkg::CELLS)) u_rough_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (idx),
		.wdata (r_wdata),
		.raddr (nb_addr),
		.rdata (r_rdata)
	);

	hne_ram #(.WIDTH(3 * hne_pkg::NORM_W), .DEPTH(hne_pkg::CELLS)) u_smooth_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (idx),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// ------------------------------------------------------------------
	// Control: state, registers, staleness flag, response register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			width_q      <= hne_pkg::GRID_RESET;
			length_q     <= hne_pkg::GRID_RESET;
			valid_q      <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_height_q <= '0;
			for (int c = 0; c < 3; c++) rsp_n_q[c] <= '0;
		end else begin
			if (cfg_wr) begin
				if (hne_pkg::reg_t'(paddr[2]) == hne_pkg::REG_GRID_LENGTH) begin
					length_q <= pwdata[hne_pkg::CFG_W-1:0];
				end else begin
					width_q <= pwdata[hne_pkg::CFG_W-1:0];
				end
			end
			if (cfg_wr || h_we) begin
				valid_q <= 1'b0;
			end else if ((state_q == S_P2_WR) && !(has_rt || has_dn)) begin
				valid_q <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q  <= 1'b1;
				rsp_height_q <= res_height_q;
				for (int c = 0; c < 3; c++) rsp_n_q[c] <= res_n_q[c];
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						unique case (req_op)
							hne_pkg::OP_WRITE: ;
							hne_pkg::OP_READ_HEIGHT: begin
								state_q <= req_inside ? S_HEIGHT : S_RESP;
							end
							hne_pkg::OP_READ_NORMAL: begin
								if (!req_inside) state_q <= S_RESP;
								else if (valid_q) state_q <= S_NORMAL;
								else state_q <= S_P1_RD;
							end
							default: ;
						endcase
					end
				end
				S_HEIGHT, S_NORMAL: state_q <= S_RESP;
				S_RESP: begin
					if (rsp_load) state_q <= S_IDLE;
				end
				S_FETCH:     state_q <= S_NORMAL;
				S_P1_RD:     state_q <= S_P1_CAP;
				S_P1_CAP:    state_q <= (rd_q == hne_pkg::NB_RT) ? S_P1_TRI : S_P1_RD;
				S_P1_TRI: begin
					if (tri_en) state_q <= S_P1_SQP;
					else if (&tri_q) state_q <= S_P1_WR;
				end
				S_P1_SQP:    state_q <= S_P1_SQQ;
				S_P1_SQQ:    state_q <= S_P1_ROOT_LD;
				S_P1_ROOT_LD: state_q <= S_P1_ROOT;
				S_P1_ROOT:   if (it_q == '0) state_q <= S_P1_DIV_LD;
				S_P1_DIV_LD: state_q <= S_P1_DIV;
				S_P1_DIV:    if (it_q == '0) state_q <= S_P1_ACC;
				S_P1_ACC:    state_q <= (&tri_q) ? S_P1_WR : S_P1_TRI;
				S_P1_WR:     state_q <= (has_rt || has_dn) ? S_P1_RD : S_P2_RD;
				S_P2_RD:     state_q <= S_P2_CAP;
				S_P2_CAP:    state_q <= (rd_q == hne_pkg::NB_RT) ? S_P2_SUM : S_P2_RD;
				S_P2_SUM:    state_q <= S_P2_WR;
				S_P2_WR:     state_q <= (has_rt || has_dn) ? S_P2_RD : S_FETCH;
				default:     state_q <= S_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					addr_q       <= req_addr;
					res_height_q <= '0;
					for (int c = 0; c < 3; c++) res_n_q[c] <= '0;
					x_q    <= '0;
					z_q    <= '0;
					base_q <= '0;
					rd_q   <= hne_pkg::NB_C;
				end
			end
			S_HEIGHT: begin
				res_height_q <= h_rdata;
			end
			S_NORMAL: begin
				for (int c = 0; c < 3; c++) begin
					res_n_q[c] <= s_rdata[c*hne_pkg::NORM_W +: hne_pkg::NORM_W];
				end
			end
			S_P1_CAP: begin
				nb_q[rd_q] <= h_rdata;
				if (rd_q == hne_pkg::NB_RT) begin
					tri_q <= '0;
					for (int c = 0; c < 3; c++) acc_q[c] <= '0;
				end else begin
					rd_q <= rd_q + 3'd1;
				end
			end
			S_P1_TRI: begin
				p_q <= tri_p;
				q_q <= tri_qv;
				if (!tri_en) tri_q <= tri_q + 2'd1;
			end
			S_P1_SQP: psq_q <= sq_full[hne_pkg::SQR_W-1:0];
			S_P1_SQQ: qsq_q <= sq_full[hne_pkg::SQR_W-1:0];
			S_P1_ROOT_LD: begin
				sqx_q  <= hne_pkg::SQ_W'(hne_pkg::SQR_W'(0) + 34'(psq_q) + 34'(qsq_q) +
					34'(hne_pkg::SQ_BIAS)) << 16;
				root_q <= '0;
				it_q   <= 5'(hne_pkg::ROOT_STEPS - 1);
			end
			S_P1_ROOT: begin
				if (root_ge) begin
					sqx_q  <= sqx_q - root_t;
					root_q <= (root_q >> 1) + bit_v;
				end else begin
					root_q <= root_q >> 1;
				end
				it_q <= it_q - 5'd1;
			end
			S_P1_DIV_LD: begin
				// Rounded quotient: (n * 2^21 + m) / (2m), one bit a cycle.
				for (int c = 0; c < 3; c++) begin
					rem_q[c] <= (hne_pkg::DIV_W'(mag_n[c]) << hne_pkg::DIV_SHIFT) +
						hne_pkg::DIV_W'(root_q[hne_pkg::ROOT_W-1:0]);
					quo_q[c] <= '0;
				end
				dsr_q <= hne_pkg::DIV_W'({root_q[hne_pkg::ROOT_W-1:0], 1'b0}) <<
					(hne_pkg::DIV_STEPS - 1);
				it_q  <= 5'(hne_pkg::DIV_STEPS - 1);
			end
			S_P1_DIV: begin
				for (int c = 0; c < 3; c++) begin
					if (rem_q[c] >= dsr_q) rem_q[c] <= rem_q[c] - dsr_q;
					quo_q[c] <= {quo_q[c][hne_pkg::QUO_W-2:0], rem_q[c] >= dsr_q};
				end
				dsr_q <= dsr_q >> 1;
				it_q  <= it_q - 5'd1;
			end
			S_P1_ACC: begin
				for (int c = 0; c < 3; c++) begin
					acc_q[c] <= neg_n[c] ? acc_q[c] - hne_pkg::ROUGH_W'(quo_q[c]) :
						acc_q[c] + hne_pkg::ROUGH_W'(quo_q[c]);
				end
				tri_q <= tri_q + 2'd1;
			end
			S_P1_WR, S_P2_WR: begin
				rd_q <= hne_pkg::NB_C;
				if (has_rt) begin
					x_q <= x_q + hne_pkg::COL_W'(1);
				end else begin
					x_q <= '0;
					if (has_dn) begin
						z_q    <= z_q + hne_pkg::ROW_W'(1);
						base_q <= base_q + hne_pkg::ADDR_W'(hne_pkg::MAX_WIDTH);
					end else begin
						z_q    <= '0;
						base_q <= '0;
					end
				end
			end
			S_P2_CAP: begin
				for (int c = 0; c < 3; c++) begin
					rn_q[rd_q][c] <= has_vec[rd_q] ?
						r_rdata[c*hne_pkg::ROUGH_W +: hne_pkg::ROUGH_W] : '0;
				end
				if (rd_q != hne_pkg::NB_RT) rd_q <= rd_q + 3'd1;
			end
			S_P2_SUM: begin
				for (int c = 0; c < 3; c++) d_q[c] <= sum_c[c];
			end
			default: ;
		endcase
	end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the height-map normal engine. A table of directed
// items runs first, then random phases under several grid sizes. Every read
// is checked against its fixed result in the table or against a behavioral
// model of the height grid and its smoothed normals kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
	import hne_pkg::*;

	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	typedef struct packed {
		logic signed [HEIGHT_W-1:0] h;
		logic signed [NORM_W-1:0]   nx;
		logic signed [NORM_W-1:0]   ny;
		logic signed [NORM_W-1:0]   nz;
	} result_t;

	typedef struct {
		bit         cfg;
		logic [1:0] op;
		int         col;
		int         row;
		int         hv;
		bit         fixed;
		result_t    res;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	hne_req_if req_ch();
	hne_rsp_if rsp_ch();

	heightmap_normal_engine uut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req_ch), .rsp(rsp_ch)
	);

	// Model state
	int      heights [CELLS];
	int      rough   [CELLS][3];
	int      smooth  [CELLS][3];
	bit      normals_fresh;
	int      cfg_w, cfg_l;
	result_t expected_q[$];
	int      errors;
	int      src_idle_pct, dst_stall_pct;

	always #2 clk = ~clk;

	initial begin
		req_ch.valid = 1'b0;
		req_ch.operation = '0;
		req_ch.column = '0;
		req_ch.row = '0;
		req_ch.height_value = '0;
		rsp_ch.ready = 1'b0;
	end

	always @(posedge clk)
		rsp_ch.ready <= (dst_stall_pct == 0) || ($urandom_range(99) >= dst_stall_pct);

	function automatic longint unsigned root64(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic int scale_q12(input int n, input longint unsigned m);
		longint unsigned a, q;
		a = (n < 0) ? -n : n;
		q = ((a << 21) + m) / (2 * m);
		return (n < 0) ? -int'(q) : int'(q);
	endfunction

	function automatic void add_triangle(inout int ax, inout int ay, inout int az,
			input int p, input int q);
		longint unsigned s, m;
		s = longint'(p) * p + longint'(q) * q + SQ_BIAS;
		m = root64(s << 16);
		ax += scale_q12(p, m);
		ay += scale_q12(UNIT_Y, m);
		az += scale_q12(q, m);
	endfunction

	function automatic int halve_sat(input int d);
		int v;
		v = (d >= 0) ? (d + 1) / 2 : -((-d + 1) / 2);
		if (v > NORM_LIMIT) v = NORM_LIMIT;
		if (v < -NORM_LIMIT) v = -NORM_LIMIT;
		return v;
	endfunction

	function automatic int span(input int raw, input int lim);
		if (raw < 1) return 1;
		return (raw > lim) ? lim : raw;
	endfunction

	function automatic void rebuild_normals();
		int w, l, i, h, up, dn, lf, rt, d;
		int s[3], r[3];
		bit hu, hd, hl, hr;
		w = span(cfg_w, MAX_WIDTH);
		l = span(cfg_l, MAX_LENGTH);
		for (int z = 0; z < l; z++)
			for (int x = 0; x < w; x++) begin
				i = z * MAX_WIDTH + x;
				h = heights[i];
				up = 0; dn = 0; lf = 0; rt = 0;
				s = '{0, 0, 0};
				hu = z > 0; hd = z + 1 < l; hl = x > 0; hr = x + 1 < w;
				if (hu) up = heights[i - MAX_WIDTH] - h;
				if (hd) dn = heights[i + MAX_WIDTH] - h;
				if (hl) lf = heights[i - 1] - h;
				if (hr) rt = heights[i + 1] - h;
				if (hl && hu) add_triangle(s[0], s[1], s[2], lf, up);
				if (hl && hd) add_triangle(s[0], s[1], s[2], lf, -dn);
				if (hr && hd) add_triangle(s[0], s[1], s[2], -rt, -dn);
				if (hr && hu) add_triangle(s[0], s[1], s[2], -rt, up);
				rough[i] = s;
			end
		for (int z = 0; z < l; z++)
			for (int x = 0; x < w; x++) begin
				i = z * MAX_WIDTH + x;
				for (int k = 0; k < 3; k++) begin
					d = 2 * rough[i][k];
					if (x > 0) d += rough[i - 1][k];
					if (x + 1 < w) d += rough[i + 1][k];
					if (z > 0) d += rough[i - MAX_WIDTH][k];
					if (z + 1 < l) d += rough[i + MAX_WIDTH][k];
					r[k] = d;
				end
				// A flat or empty neighborhood points straight up.
				if (r[0] == 0 && r[1] == 0 && r[2] == 0) r[1] = 2 * ONE_Q12;
				for (int k = 0; k < 3; k++) smooth[i][k] = halve_sat(r[k]);
			end
		normals_fresh = 1'b1;
	endfunction

	function automatic void predict_item(input logic [1:0] op, input int col, input int row,
			input int hv, output bit has, output result_t r);
		bit in_grid;
		int idx;
		in_grid = col < span(cfg_w, MAX_WIDTH) && row < span(cfg_l, MAX_LENGTH);
		idx = row * MAX_WIDTH + col;
		r = '0;
		has = 1'b0;
		case (op)
			OP_WRITE: begin
				if (in_grid) begin
					heights[idx] = hv;
					normals_fresh = 1'b0;
				end
			end
			OP_READ_HEIGHT: begin
				has = 1'b1;
				if (in_grid) r.h = HEIGHT_W'(heights[idx]);
			end
			OP_READ_NORMAL: begin
				has = 1'b1;
				if (in_grid) begin
					if (!normals_fresh) rebuild_normals();
					r.nx = NORM_W'(smooth[idx][0]);
					r.ny = NORM_W'(smooth[idx][1]);
					r.nz = NORM_W'(smooth[idx][2]);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] op, input int col, input int row, input int hv,
			input bit fixed, input result_t fixed_res);
		bit has;
		result_t r;
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.column <= COL_W'(col);
		req_ch.row <= ROW_W'(row);
		req_ch.height_value <= HEIGHT_W'(hv);
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predict_item(op, col, row, hv, has, r);
		if (has) expected_q.push_back(fixed ? fixed_res : r);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		// Writes leave no response, so give the last one time to land.
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input reg_t idx, input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_GRID_WIDTH) cfg_w = value & 7'h7F;
		else cfg_l = value & 7'h7F;
		normals_fresh = 1'b0;
	endtask

	function automatic int pick_height();
		case ($urandom_range(5))
			0: return 32767;
			1: return -32768;
			2: return int'($urandom_range(512)) - 256;
			default: return int'($signed(16'($urandom)));
		endcase
	endfunction

	always @(posedge clk) begin
		result_t got, want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.height_out, rsp_ch.normal_x, rsp_ch.normal_y, rsp_ch.normal_z};
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected beat: h=%0d n=(%0d,%0d,%0d)",
					got.h, got.nx, got.ny, got.nz);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp h=%0d n=(%0d,%0d,%0d) got h=%0d n=(%0d,%0d,%0d)",
							want.h, want.nx, want.ny, want.nz,
							got.h, got.nx, got.ny, got.nz);
				end
			end
		end
	end

	step_t steps [24] = '{
		'{0, OP_WRITE,        0,  0,  32767, 0, '{0, 0, 0, 0}},
		'{0, OP_WRITE,        63, 63, -32768, 0, '{0, 0, 0, 0}},
		'{0, OP_READ_HEIGHT,  0,  0,  0, 1, '{32767, 0, 0, 0}},
		'{0, OP_READ_HEIGHT,  63, 63, 0, 1, '{-32768, 0, 0, 0}},
		'{0, OP_UNKNOWN,      5,  5,  -1, 0, '{0, 0, 0, 0}},
		'{0, OP_WRITE,        63, 0,  21845, 0, '{0, 0, 0, 0}},
		'{0, OP_READ_HEIGHT,  63, 0,  0, 1, '{21845, 0, 0, 0}},
		'{1, REG_GRID_WIDTH,  0,  0,  0, 0, '{0, 0, 0, 0}},
		'{1, REG_GRID_LENGTH, 0,  0,  0, 0, '{0, 0, 0, 0}},
		'{0, OP_READ_NORMAL,  0,  0,  0, 1, '{0, 0, ONE_Q12, 0}},
		'{0, OP_READ_HEIGHT,  1,  0,  0, 1, '{0, 0, 0, 0}},
		'{0, OP_READ_NORMAL,  0,  1,  0, 1, '{0, 0, 0, 0}},
		'{0, OP_WRITE,        3,  3,  100, 0, '{0, 0, 0, 0}},
		'{0, OP_READ_NORMAL,  0,  0,  0, 1, '{0, 0, ONE_Q12, 0}},
		'{1, REG_GRID_WIDTH,  0,  0,  2, 0, '{0, 0, 0, 0}},
		'{1, REG_GRID_LENGTH, 0,  0,  2, 0, '{0, 0, 0, 0}},
		'{0, OP_WRITE,        1,  0,  256, 0, '{0, 0, 0, 0}},
		'{0, OP_WRITE,        0,  1,  -256, 0, '{0, 0, 0, 0}},
		'{0, OP_WRITE,        1,  1,  0, 0, '{0, 0, 0, 0}},
		'{0, OP_READ_NORMAL,  0,  0,  0, 0, '{0, 0, 0, 0}},
		'{0, OP_READ_NORMAL,  1,  1,  0, 0, '{0, 0, 0, 0}},
		'{0, OP_READ_HEIGHT,  1,  1,  0, 1, '{0, 0, 0, 0}},
		'{1, REG_GRID_WIDTH,  0,  0,  127, 0, '{0, 0, 0, 0}},
		'{1, REG_GRID_LENGTH, 0,  0,  127, 0, '{0, 0, 0, 0}}
	};

	int phase_w [11] = '{2, 5, 64, 1, 0, 127, 4, 3, 6, 2, 1};
	int phase_l [11] = '{2, 4, 1, 64, 3, 1, 4, 5, 2, 7, 1};

	initial begin
		int w, l, pick, col, row;
		logic [1:0] op;
		errors = 0;
		cfg_w = int'(GRID_RESET);
		cfg_l = int'(GRID_RESET);
		normals_fresh = 1'b0;
		foreach (heights[i]) heights[i] = 0;
		src_idle_pct = 0;
		dst_stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].cfg) begin
				drain();
				write_reg(reg_t'(steps[i].op[0]), steps[i].hv);
			end else begin
				send_item(steps[i].op, steps[i].col, steps[i].row, steps[i].hv,
					steps[i].fixed, steps[i].res);
			end
		end

		foreach (phase_w[p]) begin
			drain();
			case (p % 4)
				0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
				1: begin src_idle_pct = 49; dst_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  dst_stall_pct = 49; end
				default: begin src_idle_pct = 7; dst_stall_pct = 7; end
			endcase
			write_reg(REG_GRID_WIDTH, phase_w[p]);
			write_reg(REG_GRID_LENGTH, phase_l[p]);
			w = span(cfg_w, MAX_WIDTH);
			l = span(cfg_l, MAX_LENGTH);
			// Fill the whole grid so every later in-grid read sees written heights.
			for (int z = 0; z < l; z++)
				for (int x = 0; x < w; x++)
					send_item(OP_WRITE, x, z, pick_height(), 0, '0);
			repeat (125) begin
				pick = $urandom_range(99);
				if ($urandom_range(9) == 0) begin
					col = $urandom_range(63);
					row = $urandom_range(63);
				end else begin
					col = $urandom_range(w - 1);
					row = $urandom_range(l - 1);
				end
				if (pick < 35) op = OP_WRITE;
				else if (pick < 60) op = OP_READ_HEIGHT;
				else if (pick < 94) op = OP_READ_NORMAL;
				else op = OP_UNKNOWN;
				send_item(op, col, row, pick_height(), 0, '0);
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) $display("tb_top OK");
		else $display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
